// File: rtl/core/rmf_pkg.sv
// running median filter: shared constants and the cell control struct
// used by rmf_cell and running_median_filter; no dependencies
`default_nettype none

package rmf_pkg;

	localparam int MAX_WINDOW = 31;
	localparam int SAMPLE_W   = 16;
	localparam int WIN_W      = 5;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(5);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic load;
		logic drop_high;
		logic active;
		logic is_top;
		logic is_bottom;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/rmf_cell.sv
// one slot of the sorted store: compares, ripples the shift flags and
// takes its new value from itself, a neighbour or the new sample; uses rmf_pkg
`default_nettype none

module rmf_cell
	import rmf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire sample_t    sample,
	input  wire sample_t    val_dn,
	input  wire sample_t    val_up,
	input  wire logic       hi_up,
	input  wire logic       hi_dn,
	input  wire logic       lo_up,
	input  wire logic       lo_dn,
	output sample_t         val,
	output sample_t         val_nxt,
	output logic            hi,
	output logic            lo
);

	sample_t val_q;
	logic    gt;
	logic    lt;

	assign gt = val_q > sample;
	assign lt = val_q < sample;

	// run of larger entries from the top slot down, smaller ones from slot zero up
	assign hi = ctrl.is_top || (ctrl.active && gt && hi_up);
	assign lo = ctrl.is_bottom || (ctrl.active && lt && lo_dn);

	always_comb begin
		val_nxt = val_q;
		if (ctrl.load) begin
			if (ctrl.drop_high) begin
				if (hi && hi_dn) begin
					val_nxt = val_dn;
				end else if (hi) begin
					val_nxt = sample;
				end
			end else begin
				if (lo_up) begin
					val_nxt = val_up;
				end else if (lo) begin
					val_nxt = sample;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else begin
			val_q <= val_nxt;
		end
	end

	assign val = val_q;

endmodule

`default_nettype wire

// File: rtl/core/running_median_filter.sv
// Running median filter over a sorted window of signed 16-bit samples. Takes one sample
// per clock unless stalled, with one median per sample in the cycle after the transfer; a
// stall on the output holds only while the result register is full. The insertion ripples
// through a row of MAX_WINDOW compare-and-shift cells in the same cycle, and that ripple
// sets the clock path. The store reads zero after reset until written; window_size is
// clamped to 1..MAX_WINDOW and should be written only while no result is pending.
// top level; uses rmf_pkg and rmf_cell
`default_nettype none

module running_median_filter
	import rmf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [WIN_W-1:0]    cfg_wdata,     // window_size
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [SAMPLE_W-1:0] s_axis_tdata,  // sample
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [SAMPLE_W-1:0]      m_axis_tdata   // median
);

	logic [WIN_W-1:0] win_q;
	logic [CNT_W-1:0] fill_q;
	logic             drop_high_q;
	logic             out_valid_q;
	sample_t          median_q;

	logic [CNT_W-1:0] win_c;
	logic [CNT_W-1:0] fill_c;
	logic [CNT_W-1:0] fill_n;
	logic             filling;
	logic             drop_high;
	logic             in_xfer;
	sample_t          sample;

	sample_t              val     [MAX_WINDOW];
	sample_t              val_nxt [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] hi;
	logic [MAX_WINDOW-1:0] lo;

	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign sample        = sample_t'(s_axis_tdata);

	always_comb begin
		if (win_q == '0) begin
			win_c = CNT_W'(1);
		end else if (int'(win_q) > MAX_WINDOW) begin
			win_c = CNT_W'(MAX_WINDOW);
		end else begin
			win_c = CNT_W'(win_q);
		end
		fill_c    = (fill_q > win_c) ? win_c : fill_q;
		filling   = fill_c < win_c;
		fill_n    = filling ? fill_c + CNT_W'(1) : fill_c;
		drop_high = filling || drop_high_q;
	end

	genvar k;
	generate
		for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
			cell_ctrl_t ctrl;
			sample_t    v_dn;
			sample_t    v_up;
			logic       h_up;
			logic       h_dn;
			logic       l_up;
			logic       l_dn;

			assign ctrl.load      = in_xfer;
			assign ctrl.drop_high = drop_high;
			assign ctrl.active    = CNT_W'(k) < fill_n;
			assign ctrl.is_top    = fill_n == CNT_W'(k + 1);
			assign ctrl.is_bottom = (k == 0);

			if (k == 0) begin : g_bot
				assign v_dn = '0;
				assign h_dn = 1'b0;
				assign l_dn = 1'b0;
			end else begin : g_mid_dn
				assign v_dn = val[k-1];
				assign h_dn = hi[k-1];
				assign l_dn = lo[k-1];
			end

			if (k == MAX_WINDOW - 1) begin : g_top
				assign v_up = '0;
				assign h_up = 1'b0;
				assign l_up = 1'b0;
			end else begin : g_mid_up
				assign v_up = val[k+1];
				assign h_up = hi[k+1];
				assign l_up = lo[k+1];
			end

			rmf_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.sample  (sample),
				.val_dn  (v_dn),
				.val_up  (v_up),
				.hi_up   (h_up),
				.hi_dn   (h_dn),
				.lo_up   (l_up),
				.lo_dn   (l_dn),
				.val     (val[k]),
				.val_nxt (val_nxt[k]),
				.hi      (hi[k]),
				.lo      (lo[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= WIN_RESET;
			fill_q      <= '0;
			drop_high_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_q <= cfg_wdata;
			end
			if (in_xfer) begin
				fill_q      <= fill_n;
				drop_high_q <= !drop_high;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			median_q <= val_nxt[IDX_W'(win_c >> 1)];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = median_q;

`ifndef SYNTHESIS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> m_axis_tvalid)
		else $error("no result after input transfer");

	a_drop_alternates: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !filling) |=> (drop_high_q != $past(drop_high_q)))
		else $error("drop end did not alternate on a full window");

	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (fill_q != '0) && (fill_q <= CNT_W'(MAX_WINDOW)))
		else $error("fill count out of range after transfer");
`endif

endmodule

`default_nettype wire

// File: tb/running_median_filter_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for running_median_filter: keeps its own sorted window per sample
// and checks every median transfer in order, under random source gaps and sink stalls
// depends on rmf_pkg and the running_median_filter rtl

module running_median_filter_tb;
	import rmf_pkg::*;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                cfg_we        = 1'b0;
	logic [WIN_W-1:0]    cfg_wdata     = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [SAMPLE_W-1:0] s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_axis_tdata;

	sample_t          window_store [MAX_WINDOW];
	int unsigned      fill_level = 0;
	bit               drop_high  = 1'b0;
	logic [WIN_W-1:0] window_reg = WIN_RESET;
	sample_t          median_q [$];
	sample_t          expected_median;
	int unsigned      gap_pct     = 0;
	int unsigned      stall_pct   = 0;
	int unsigned      error_count = 0;

	always #10 clk = ~clk;

	running_median_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		for (int k = 0; k < MAX_WINDOW; k++) window_store[k] = '0;
	end

	// insert one sample into the sorted window and queue the median it yields
	task automatic predict_median(input sample_t s);
		int unsigned w;
		int unsigned i;
		w = (window_reg == 0) ? 1 : window_reg;
		if (w > MAX_WINDOW) w = MAX_WINDOW;
		if (fill_level > w) fill_level = w;
		if (fill_level < w) begin
			fill_level++;
			drop_high = 1'b1;
		end
		if (drop_high) begin
			i = fill_level - 1;
			while (i > 0 && window_store[i-1] > s) begin
				window_store[i] = window_store[i-1];
				i--;
			end
		end else begin
			i = 0;
			while (i + 1 < fill_level && window_store[i+1] < s) begin
				window_store[i] = window_store[i+1];
				i++;
			end
		end
		window_store[i] = s;
		drop_high = !drop_high;
		median_q.push_back(window_store[w/2]);
	endtask

	task automatic send_sample(input sample_t s);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= s;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_median(s);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (median_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_window(input logic [WIN_W-1:0] w);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we     <= 1'b0;
		window_reg  = w;
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(9))
			0: return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
			1, 2, 3: return sample_t'(int'($urandom_range(8)) - 4);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [WIN_W-1:0] pick_window();
		case ($urandom_range(9))
			0: return WIN_W'($urandom_range(1));
			1: return WIN_W'(MAX_WINDOW);
			2, 3: return WIN_W'($urandom_range(31));
			default: return WIN_W'(2 * $urandom_range(1, 7) + 1);
		endcase
	endfunction

	// unwritten entries read zero while the default window fills
	task automatic test_fill_from_reset();
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(16'sh5555);
		send_sample(16'shaaaa);
	endtask

	// zero window acts as one, even window takes the entry at half
	task automatic test_window_extremes();
		set_window(WIN_W'(0));
		send_sample(-16'sd7);
		send_sample(16'sd7);
		set_window(WIN_W'(2));
		send_sample(16'sd300);
		send_sample(-16'sd300);
	endtask

	// stale entries above a shrunken window come back when it grows
	task automatic test_shrink_grow();
		set_window(WIN_W'(MAX_WINDOW));
		send_sample(16'sd100);
		send_sample(16'sd100);
		send_sample(-16'sd50);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sd100);
		set_window(WIN_W'(3));
		send_sample(16'sd0);
		send_sample(16'sd200);
		send_sample(-16'sd200);
		set_window(WIN_W'(MAX_WINDOW));
		send_sample(16'sd1);
		send_sample(-16'sd1);
	endtask

	task automatic test_random_phase(input int unsigned gap, input int unsigned stall,
	                                 input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		bit          first_seg;
		gap_pct   = gap;
		stall_pct = stall;
		sent      = 0;
		first_seg = 1'b1;
		while (sent < n_items) begin
			set_window(pick_window());
			len = $urandom_range(20, 120);
			for (int unsigned k = 0; k < len && sent < n_items; k++) begin
				// source holds off until every median is back
				if (k == len / 2 && (first_seg || $urandom_range(3) == 0)) wait_drained();
				send_sample(pick_sample());
				sent++;
			end
			first_seg = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (median_q.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("median transfer with nothing pending: %0d",
					         $signed(m_axis_tdata));
			end else begin
				expected_median = median_q.pop_front();
				if (m_axis_tdata !== expected_median) begin
					error_count++;
					if (error_count <= 10)
						$display("median mismatch: expected %0d, got %0d",
						         expected_median, $signed(m_axis_tdata));
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		gap_pct   = 13;
		stall_pct = 65;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_from_reset();
		test_window_extremes();
		test_shrink_grow();
		test_random_phase(13, 65, 620);
		test_random_phase(65, 13, 620);
		test_random_phase(0, 0, 610);
		wait_drained();
		if (error_count == 0 && median_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: files.f
rtl/core/rmf_pkg.sv
rtl/core/rmf_cell.sv
rtl/core/running_median_filter.sv
tb/running_median_filter_tb.sv
